// ===== hdl/lcas_pkg.sv =====
// Package for the Life generation step: field widths, register indexes,
// per-cell stage flags and the neighborhood rule. No dependencies.
package lcas_pkg;

    localparam int GRID_W     = 11;     // width of grid_width / grid_height
    localparam int ROW_W      = 11;     // input row counter, holds up to height + 1
    localparam int CFG_IDX_W  = 4;
    localparam int STORE_W    = 2;      // line store bits per column
    localparam int MIN_DIM    = 3;
    localparam int MAX_HEIGHT = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 4'd1;

    localparam logic REQ_CELL  = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // flags that travel with a request from the counters to the window stage
    typedef struct packed {
        logic alive;
        logic c_zero;
        logic emit;
        logic last;
        logic row_ge1;
        logic row_ge2;
    } t_stage;

    function automatic logic [1:0] col_count(input logic [2:0] col);
        col_count = 2'(col[0]) + 2'(col[1]) + 2'(col[2]);
    endfunction

    // B3/S23 with the center included in the sum
    function automatic logic life_rule(input logic [1:0] cnt_new,
                                       input logic [1:0] cnt_mid,
                                       input logic [1:0] cnt_old,
                                       input logic       center);
        logic [3:0] sum;
        sum = 4'(cnt_new) + 4'(cnt_mid) + 4'(cnt_old);
        life_rule = (sum == 4'd3) || (center && (sum == 4'd4));
    endfunction

endpackage

// ===== hdl/lcas_if.sv =====
// Valid/ready channel interfaces for the Life generation step:
// cell request input, result output and register write port. Uses lcas_pkg.
interface lcas_in_if;
    logic valid;
    logic ready;
    logic req_type;
    logic cell_alive;
    modport source (output valid, output req_type, output cell_alive, input ready);
    modport sink   (input valid, input req_type, input cell_alive, output ready);
endinterface

interface lcas_out_if;
    logic valid;
    logic ready;
    logic next_alive;
    logic out_last;
    modport source (output valid, output next_alive, output out_last, input ready);
    modport sink   (input valid, input next_alive, input out_last, output ready);
endinterface

interface lcas_cfg_if
    import lcas_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GRID_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/lcas_line_store.sv =====
// Two-row line store of the Life step: one read and one write port,
// registered read data. Depends on lcas_pkg.
module lcas_line_store
    import lcas_pkg::*;
#(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [STORE_W-1:0] o_rd_data,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [STORE_W-1:0] i_wr_data
);

    logic [STORE_W-1:0] r_mem [DEPTH];
    logic [STORE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/lcas_col_cell.sv =====
// One column cell of the 3x3 window: holds three rows of a column and their
// live count, and hands them to the next cell on each shift. Uses lcas_pkg.
module lcas_col_cell
    import lcas_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic       i_clear,
    input  logic [2:0] i_col,
    output logic [2:0] o_col,
    output logic [1:0] o_cnt
);

    logic [2:0] r_col, n_col;
    logic [1:0] r_cnt, n_cnt;

    always_comb begin
        n_col = r_col;
        n_cnt = r_cnt;
        if (i_load) begin
            n_col = i_clear ? 3'b000 : i_col;
            n_cnt = i_clear ? 2'd0 : col_count(i_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 3'b000;
            r_cnt <= 2'd0;
        end else begin
            r_col <= n_col;
            r_cnt <= n_cnt;
        end
    end

    assign o_col = r_col;
    assign o_cnt = r_cnt;

endmodule

// ===== hdl/life_cellular_automaton_step.sv =====
// One Life generation (B3/S23) over a raster-order grid, one cell request
// per cycle sustained unless the output stalls; the line store read port
// and the two-cell window chain advance together. A result leaves, in grid
// terms, one row plus one column later (grid_width+1 flush requests).
// Reset: grid size 1024x1024, counters zero, window dead; the line store is
// not cleared, the first two rows of a frame mask it.
module life_cellular_automaton_step
    import lcas_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcas_in_if.sink     i_in,
    lcas_out_if.source  o_out,
    lcas_cfg_if.sink    i_cfg
);

    localparam int COLW = $clog2(MAX_WIDTH);
    localparam int EW   = (COLW + 1 > GRID_W) ? COLW + 1 : GRID_W;

    // ---------------- configuration ----------------
    logic [GRID_W-1:0] r_grid_width, r_grid_height;
    logic              w_cfg_wr, w_restart;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid && i_cfg.ready;
    assign w_restart   = w_cfg_wr &&
                         (i_cfg.index == CFG_GRID_WIDTH || i_cfg.index == CFG_GRID_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_W'(1024);
            r_grid_height <= GRID_W'(1024);
        end else if (w_cfg_wr) begin
            if (i_cfg.index == CFG_GRID_WIDTH) begin
                r_grid_width <= i_cfg.data;
            end
            if (i_cfg.index == CFG_GRID_HEIGHT) begin
                r_grid_height <= i_cfg.data;
            end
        end
    end

    logic [EW-1:0]     w_gw, w_eff_w;
    logic [COLW-1:0]   w_last_col;
    logic [GRID_W-1:0] w_eff_h;
    logic [ROW_W:0]    w_end_row;

    assign w_gw = EW'(r_grid_width);

    always_comb begin
        if (w_gw < EW'(MIN_DIM)) begin
            w_eff_w = EW'(MIN_DIM);
        end else if (w_gw > EW'(MAX_WIDTH)) begin
            w_eff_w = EW'(MAX_WIDTH);
        end else begin
            w_eff_w = w_gw;
        end
        if (r_grid_height < GRID_W'(MIN_DIM)) begin
            w_eff_h = GRID_W'(MIN_DIM);
        end else if (r_grid_height > GRID_W'(MAX_HEIGHT)) begin
            w_eff_h = GRID_W'(MAX_HEIGHT);
        end else begin
            w_eff_h = r_grid_height;
        end
    end

    assign w_last_col = COLW'(w_eff_w - EW'(1));
    // last result of a frame leaves on column 0 of row height + 1
    assign w_end_row  = (ROW_W + 1)'(w_eff_h) + (ROW_W + 1)'(1);

    // ---------------- input counters ----------------
    logic [COLW-1:0]  r_in_col, n_in_col;
    logic [ROW_W-1:0] r_in_row, n_in_row;
    logic             w_in_acc, w_s1_fire;
    logic             w_c_zero, w_col_end, w_last;
    t_stage           w_stage;

    assign w_c_zero  = (r_in_col == '0);
    assign w_col_end = (r_in_col == w_last_col);
    assign w_last    = ((ROW_W + 1)'(r_in_row) == w_end_row) && w_c_zero;

    always_comb begin
        w_stage.alive   = (i_in.req_type == REQ_CELL) && i_in.cell_alive &&
                          (r_in_row < ROW_W'(w_eff_h));
        w_stage.c_zero  = w_c_zero;
        w_stage.row_ge1 = (r_in_row != '0);
        w_stage.row_ge2 = |r_in_row[ROW_W-1:1];
        w_stage.emit    = w_stage.row_ge2 || ((r_in_row == ROW_W'(1)) && !w_c_zero);
        w_stage.last    = w_last;
    end

    always_comb begin
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        if (w_restart) begin
            n_in_col = '0;
            n_in_row = '0;
        end else if (w_in_acc) begin
            if (w_last) begin
                n_in_col = '0;
                n_in_row = '0;
            end else if (w_col_end) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = r_in_col + COLW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
        end else begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
        end
    end

    // ---------------- window stage ----------------
    logic               r_s1_valid, n_s1_valid;
    t_stage             r_s1;
    logic [COLW-1:0]    r_s1_addr;
    logic [STORE_W-1:0] w_stored;
    logic               w_mid, w_top;
    logic [2:0]         w_col;
    logic               r_out_valid, n_out_valid;
    logic               r_next_alive, r_out_last;

    assign w_s1_fire  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_s1_fire;
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign n_s1_valid = w_in_acc || (r_s1_valid && !w_s1_fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1      <= w_stage;
            r_s1_addr <= r_in_col;
        end
    end

    lcas_line_store #(.DEPTH(MAX_WIDTH)) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (r_in_col),
        .o_rd_data (w_stored),
        .i_wr_en   (w_s1_fire),
        .i_wr_addr (r_s1_addr),
        .i_wr_data ({w_mid, r_s1.alive})
    );

    // bit 0 of the store is the row just above, bit 1 the row above that
    assign w_mid = r_s1.row_ge1 && w_stored[0];
    assign w_top = r_s1.row_ge2 && w_stored[1];
    assign w_col = {r_s1.alive, w_mid, w_top};

    logic [2:0] w_cell_a_col, w_cell_b_col;
    logic [1:0] w_cell_a_cnt, w_cell_b_cnt, w_new_cnt;

    lcas_col_cell u_cell_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_s1_fire || w_restart),
        .i_clear (w_restart),
        .i_col   (w_col),
        .o_col   (w_cell_a_col),
        .o_cnt   (w_cell_a_cnt)
    );

    // a row start drops the older columns: left of the grid is dead
    lcas_col_cell u_cell_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_s1_fire || w_restart),
        .i_clear (w_restart || r_s1.c_zero),
        .i_col   (w_cell_a_col),
        .o_col   (w_cell_b_col),
        .o_cnt   (w_cell_b_cnt)
    );

    // on column 0 the result is the previous row's last cell; right side dead
    assign w_new_cnt = r_s1.c_zero ? 2'd0 : col_count(w_col);

    // ---------------- output register ----------------
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_s1_fire) begin
            n_out_valid = r_s1.emit;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire && r_s1.emit) begin
            r_next_alive <= life_rule(w_new_cnt, w_cell_a_cnt, w_cell_b_cnt, w_cell_a_col[1]);
            r_out_last   <= r_s1.last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.next_alive = r_next_alive;
    assign o_out.out_last   = r_out_last;

    // ---------------- assertions ----------------
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while window stage is stalled");

    a_frame_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_last) |=> (r_in_col == '0 && r_in_row == '0))
        else $error("counters not restarted after frame end");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_col <= w_last_col)
        else $error("input column beyond grid width");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ROW_W + 1)'(r_in_row) <= w_end_row)
        else $error("input row beyond frame end");

endmodule
